// ----- hw/rtl/lcht_pkg.sv -----
package lcht_pkg;

  localparam int ENTRIES_DEF  = 32;
  localparam int KEY_BITS_DEF = 64;

  localparam int IN_KEY_W = 64;
  localparam int CAP_W    = 6;
  localparam int TIME_W   = 32;

  localparam logic [TIME_W-1:0] HIT_COST  = TIME_W'(1);
  localparam logic [TIME_W-1:0] MISS_COST = TIME_W'(5);

  typedef struct packed {
    logic                hit;
    logic                ev_valid;
    logic [IN_KEY_W-1:0] ev_key;
  } lookup_res_t;

endpackage

// ----- hw/rtl/lru_cache_hit_miss_timer.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_lookup_key
// out       out_valid / out_ready  out_hit, out_evicted_valid, out_evicted_key,
//                                  out_total_time
// cfg       cfg_valid / cfg_ready  cfg_capacity
//
// One item per cycle while out_ready is high, through the input and result registers.
// All entries are compared in parallel and reordered by one shift in the
// single stage between the input register and the result register.
// Reset is synchronous; it empties the cache, clears capacity and time.
// A stall holds the input register; in_ready is high while it is empty or can advance.
module lru_cache_hit_miss_timer #(
  parameter int ENTRIES  = lcht_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lcht_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lcht_pkg::IN_KEY_W-1:0] in_lookup_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic                          out_evicted_valid,
  output logic [lcht_pkg::IN_KEY_W-1:0] out_evicted_key,
  output logic [lcht_pkg::TIME_W-1:0]   out_total_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcht_pkg::CAP_W-1:0]    cfg_capacity
);
  import lcht_pkg::*;

  logic                in_vld_r;
  logic [IN_KEY_W-1:0] in_key_r;
  logic                out_vld_r;
  logic                out_hit_r, out_ev_vld_r;
  logic [IN_KEY_W-1:0] out_ev_key_r;
  logic [TIME_W-1:0]   out_time_r;
  logic                adv, fire, cfg_we;
  lookup_res_t         res;
  logic [TIME_W-1:0]   sum_nxt;

  assign adv       = !out_vld_r || out_ready;
  assign fire      = in_vld_r && adv;
  assign in_ready  = !in_vld_r || adv;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  lcht_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_capacity (cfg_capacity),
    .fire         (fire),
    .lookup_key   (in_key_r),
    .res          (res)
  );

  lcht_timer u_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .hit     (res.hit),
    .sum_nxt (sum_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_key_r <= in_lookup_key;
    end
    if (fire) begin
      out_hit_r    <= res.hit;
      out_ev_vld_r <= res.ev_valid;
      out_ev_key_r <= res.ev_key;
      out_time_r   <= sum_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_key   = out_ev_key_r;
  assign out_total_time    = out_time_r;

endmodule

// ----- hw/rtl/lcht_store.sv -----
module lcht_store #(
  parameter int ENTRIES  = 32,
  parameter int KEY_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lcht_pkg::CAP_W-1:0]    cfg_capacity,
  input  logic                          fire,
  input  logic [lcht_pkg::IN_KEY_W-1:0] lookup_key,
  output lcht_pkg::lookup_res_t         res
);
  import lcht_pkg::*;

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [KEY_BITS-1:0] slot_r   [ENTRIES];
  logic [KEY_BITS-1:0] slot_nxt [ENTRIES];
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [CAP_W-1:0]    cap_r;
  logic [CMP_W-1:0]    cap_ext;
  logic [OCC_W-1:0]    cap_eff;
  logic [KEY_BITS-1:0] key;
  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  ge_pos;
  logic                hit, full, evict, ins_new;

  assign key     = lookup_key[KEY_BITS-1:0];
  assign cap_ext = CMP_W'(cap_r);
  assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(cap_ext);
  assign hit     = |match;
  assign full    = (occ_r >= cap_eff);
  assign evict   = !hit && (cap_eff != '0) && full;
  assign ins_new = !hit && (cap_eff != '0) && !full;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = (OCC_W'(i) < occ_r) && (slot_r[i] == key);
      ge_pos[i] = |(match & ~({ENTRIES{1'b1}} << (i + 1)));
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
    logic [KEY_BITS-1:0] src;
    logic                shift_en, key_en;

    if (g < ENTRIES - 1) begin : g_src
      assign src = slot_r[g+1];
    end else begin : g_last
      assign src = slot_r[g];
    end

    assign shift_en = (hit ? ge_pos[g] : evict) && (OCC_W'(g + 1) < occ_r);
    assign key_en   = ((hit || evict) && (OCC_W'(g + 1) == occ_r)) ||
                      (ins_new && (OCC_W'(g) == occ_r));

    always_comb begin
      slot_nxt[g] = slot_r[g];
      if (key_en) begin
        slot_nxt[g] = key;
      end else if (shift_en) begin
        slot_nxt[g] = src;
      end
    end

    always_ff @(posedge clk) begin
      if (fire) begin
        slot_r[g] <= slot_nxt[g];
      end
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cfg_we) begin
      occ_nxt = '0;
    end else if (fire && ins_new) begin
      occ_nxt = occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      cap_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  assign res.hit      = hit;
  assign res.ev_valid = evict;
  assign res.ev_key   = evict ? IN_KEY_W'(slot_r[0]) : '0;

endmodule

// ----- hw/rtl/lcht_timer.sv -----
module lcht_timer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic                        hit,
  output logic [lcht_pkg::TIME_W-1:0] sum_nxt
);
  import lcht_pkg::*;

  logic [TIME_W-1:0] sum_r;
  logic [TIME_W:0]   sum_wide;

  assign sum_wide = {1'b0, sum_r} + {1'b0, (hit ? HIT_COST : MISS_COST)};
  assign sum_nxt  = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (fire) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ----- tb/lru_cache_hit_miss_timer_tb.sv -----
`timescale 1ns / 1ps

module lru_cache_hit_miss_timer_tb;
  import lcht_pkg::*;

  typedef struct packed {
    lookup_res_t         res;
    logic [TIME_W-1:0]   total;
  } access_result_t;

  typedef enum logic {ROW_CFG, ROW_KEY} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [IN_KEY_W-1:0] data;
    bit                  typed;
    access_result_t      want;
  } stim_row_t;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [IN_KEY_W-1:0] in_lookup_key = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic                out_evicted_valid;
  logic [IN_KEY_W-1:0] out_evicted_key;
  logic [TIME_W-1:0]   out_total_time;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_capacity = '0;

  // cache shadow: index 0 is least recently used
  logic [IN_KEY_W-1:0] lru_keys[$];
  logic [CAP_W-1:0]    cap_setting = '0;
  logic [TIME_W-1:0]   time_total = '0;
  access_result_t      pending_results[$];

  stim_row_t           directed_rows[$];
  logic [IN_KEY_W-1:0] key_pool[$];
  int                  src_idle_pct = 0;
  int                  sink_stall_pct = 0;
  int                  fail_cnt = 0;

  lru_cache_hit_miss_timer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_lookup_key    (in_lookup_key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_key  (out_evicted_key),
    .out_total_time   (out_total_time),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_capacity     (cfg_capacity)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic int unsigned usable_entries();
    return (cap_setting > ENTRIES_DEF) ? ENTRIES_DEF : cap_setting;
  endfunction

  function automatic access_result_t cache_access(input logic [IN_KEY_W-1:0] k);
    access_result_t    r;
    int                pos;
    logic [TIME_W-1:0] cost;
    logic [TIME_W:0]   sum;
    r = '0;
    pos = -1;
    foreach (lru_keys[i]) begin
      if (pos < 0 && lru_keys[i] == k) pos = i;
    end
    if (pos >= 0) begin
      lru_keys.delete(pos);
      lru_keys = {lru_keys, k};
      r.res.hit = 1'b1;
      cost = HIT_COST;
    end else begin
      if (usable_entries() > 0) begin
        if (lru_keys.size() >= usable_entries()) begin
          r.res.ev_valid = 1'b1;
          r.res.ev_key = lru_keys[0];
          lru_keys.delete(0);
        end
        lru_keys = {lru_keys, k};
      end
      cost = MISS_COST;
    end
    sum = {1'b0, time_total} + {1'b0, cost};
    time_total = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    r.total = time_total;
    return r;
  endfunction

  task automatic add_row(input row_kind_e kind, input logic [IN_KEY_W-1:0] data,
                         input bit typed, input logic hit, input logic ev_valid,
                         input logic [IN_KEY_W-1:0] ev_key,
                         input logic [TIME_W-1:0] total);
    stim_row_t row;
    row.kind = kind;
    row.data = data;
    row.typed = typed;
    row.want.res.hit = hit;
    row.want.res.ev_valid = ev_valid;
    row.want.res.ev_key = ev_key;
    row.want.total = total;
    directed_rows = {directed_rows, row};
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_setting = c;
    lru_keys.delete();
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_capacity <= $urandom_range(0, 63);
  endtask

  task automatic send_key(input logic [IN_KEY_W-1:0] k, input bit typed,
                          input access_result_t typed_want);
    access_result_t want;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      in_lookup_key <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_lookup_key <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = cache_access(k);
    if (typed) want = typed_want;
    pending_results = {pending_results, want};
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      IDLE_SRC: begin
        src_idle_pct = 54;
        sink_stall_pct = 0;
      end
      IDLE_SINK: begin
        src_idle_pct = 0;
        sink_stall_pct = 54;
      end
      default: begin
        src_idle_pct = 18;
        sink_stall_pct = 18;
      end
    endcase
  endtask

  always @(posedge clk) begin
    access_result_t got;
    access_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.res.hit = out_hit;
      got.res.ev_valid = out_evicted_valid;
      got.res.ev_key = out_evicted_key;
      got.total = out_total_time;
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected result hit=%0b ev=%0b ev_key=%h time=%0d", $realtime,
                   got.res.hit, got.res.ev_valid, got.res.ev_key, got.total);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.res.hit !== want.res.hit || got.res.ev_valid !== want.res.ev_valid ||
            got.res.ev_key !== want.res.ev_key || got.total !== want.total) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: mismatch exp hit=%0b ev=%0b ev_key=%h time=%0d / got hit=%0b ev=%0b ev_key=%h time=%0d",
                     $realtime, want.res.hit, want.res.ev_valid, want.res.ev_key, want.total,
                     got.res.hit, got.res.ev_valid, got.res.ev_key, got.total);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("lru_cache_hit_miss_timer_tb NOT OK");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0]    phase_caps[12];
    logic [IN_KEY_W-1:0] k;
    int                  pool_size;
    int                  pick;
    phase_caps = '{6'd1, 6'd2, 6'd32, 6'd5, 6'd0, 6'd63, 6'd8, 6'd16, 6'd33, 6'd4,
                   6'd31, 6'd3};

    // capacity zero after reset
    add_row(ROW_KEY, 64'd0, 1, 0, 0, 64'd0, 32'd5);
    add_row(ROW_KEY, '1, 1, 0, 0, 64'd0, 32'd10);
    add_row(ROW_CFG, 64'd1, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'd1, 1, 0, 0, 64'd0, 32'd15);
    add_row(ROW_KEY, 64'd1, 1, 1, 0, 64'd0, 32'd16);
    add_row(ROW_KEY, '1, 1, 0, 1, 64'd1, 32'd21);
    add_row(ROW_KEY, 64'd0, 1, 0, 1, '1, 32'd26);
    add_row(ROW_CFG, 64'd3, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'd10, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'd20, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'd30, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'd10, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'd40, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'd30, 0, 0, 0, 64'd0, 32'd0);
    // capacity beyond the entry count
    add_row(ROW_CFG, 64'd63, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'h8000_0000_0000_0000, 1, 0, 0, 64'd0, 32'd53);
    add_row(ROW_KEY, 64'h8000_0000_0000_0000, 1, 1, 0, 64'd0, 32'd54);
    add_row(ROW_KEY, 64'h5555_5555_5555_5555, 0, 0, 0, 64'd0, 32'd0);
    // write flushes; capacity zero stores nothing
    add_row(ROW_CFG, 64'd0, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'h8000_0000_0000_0000, 1, 0, 0, 64'd0, 32'd64);
    add_row(ROW_KEY, 64'h8000_0000_0000_0000, 1, 0, 0, 64'd0, 32'd69);
    add_row(ROW_CFG, 64'd33, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 64'd0, 32'd0);
    add_row(ROW_KEY, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 64'd0, 32'd0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    set_idle(IDLE_BOTH);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_capacity(directed_rows[i].data[CAP_W-1:0]);
      else
        send_key(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < 12; p++) begin
      write_capacity(phase_caps[p]);
      set_idle(idle_mode_e'(p % 4));
      pool_size = usable_entries() + $urandom_range(1, usable_entries() / 2 + 2);
      key_pool.delete();
      repeat (pool_size) begin
        k = {$urandom, $urandom};
        key_pool = {key_pool, k};
      end
      for (int i = 0; i < 110; i++) begin
        if (p == 2 && i == 55) drain_results();
        pick = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, pool_size - 1)];
        if (pick >= 90)
          k = {$urandom, $urandom};
        else if (pick >= 80)
          k = k ^ (64'd1 << $urandom_range(0, 63));
        send_key(k, 0, '0);
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("lru_cache_hit_miss_timer_tb OK");
    end else begin
      $display("lru_cache_hit_miss_timer_tb NOT OK");
    end
    $finish;
  end

endmodule
